### rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is active
`define DPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, held off while reset is active
`define DPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/dpc_pkg.sv
// types, widths and helpers for the disc pair collision pipeline
`timescale 1ns / 1ps
`default_nettype none
package dpc_pkg;

	// field widths
	localparam int VW    = 24;             // position / velocity, signed Q8.16
	localparam int MW    = 16;             // mass, unsigned Q8.8
	localparam int CDW   = 23;             // contact distance, unsigned Q7.16
	// derived datapath widths
	localparam int AMW   = VW + 1 + MW + 1; // |d| * 2m
	localparam int PW    = 2 * VW + 2;      // closing speed magnitude
	localparam int PH    = PW / 2;          // half of p for the split multiply
	localparam int DENW  = MW + 1 + 2 * CDW; // (ma + mb) * |d|^2
	localparam int NUMW  = AMW + PW;        // |d| * 2m * p
	localparam int QBITS = VW;              // quotient bits kept before clamping
	localparam int NSTG  = 7 + QBITS + 1;   // front stages, divide steps, output

	localparam logic [CDW-1:0] CD_RESET = CDW'(65536);

	localparam logic signed [VW+1:0] SAT_MAX = $signed({3'b000, {(VW-1){1'b1}}});
	localparam logic signed [VW+1:0] SAT_MIN = $signed({3'b111, {(VW-1){1'b0}}});

	typedef struct packed {
		logic [VW-1:0] vax;
		logic [VW-1:0] vay;
		logic [VW-1:0] vbx;
		logic [VW-1:0] vby;
	} vel_t;

	typedef struct packed {
		logic [DENW-1:0]  rem;
		logic [QBITS-1:0] nbits;
		logic [QBITS-1:0] q;
		logic             ovf;
	} div_lane_t;

	typedef struct packed {
		logic            hit;
		logic            sgn_x;
		logic            sgn_y;
		vel_t            vel;
		logic [DENW-1:0] den;
	} div_side_t;

	typedef struct packed {
		logic          hit;
		logic [VW-1:0] nax;
		logic [VW-1:0] nay;
		logic [VW-1:0] nbx;
		logic [VW-1:0] nby;
	} result_t;

	// one restoring divide step: shift in a numerator bit, subtract if it fits
	function automatic div_lane_t div_step(input div_lane_t l, input logic [DENW-1:0] den);
		logic [DENW:0] r2;
		logic          ge;
		div_lane_t     o;
		r2      = {l.rem, l.nbits[QBITS-1]};
		ge      = (r2 >= {1'b0, den});
		o.rem   = ge ? DENW'(r2 - {1'b0, den}) : r2[DENW-1:0];
		o.nbits = {l.nbits[QBITS-2:0], 1'b0};
		o.q     = {l.q[QBITS-2:0], ge};
		o.ovf   = l.ovf;
		return o;
	endfunction

	// velocity plus or minus a quotient magnitude, saturated to the field range
	function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] v, input logic [QBITS:0] q,
		input logic neg);
		logic signed [VW+1:0] vx;
		logic signed [VW+1:0] qx;
		logic signed [VW+1:0] s;
		vx = {{2{v[VW-1]}}, v};
		qx = {1'b0, q};
		s  = neg ? vx - qx : vx + qx;
		if (s > SAT_MAX) begin
			return SAT_MAX[VW-1:0];
		end else if (s < SAT_MIN) begin
			return SAT_MIN[VW-1:0];
		end
		return s[VW-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/disc_pair_collision.sv
// disc pair collision test and elastic response, fully pipelined
//
//   channel  dir  handshake              beat contents
//   cfg      in   cfg_wr_en              contact_distance (cfg_wr_data)
//   in       in   in_valid / in_ready    positions, velocities, masses, pocketed flags
//   out      out  out_valid / out_ready  hit, new velocities
//
// one pair per cycle while the skid is empty; the path runs through 7 front stages,
// 24 restoring divide steps (one quotient bit per stage) and the output register.
// arst_n clears the valid bits, the skid flag and contact_distance (to 1.0).
// the pipeline advances as a whole while the one-entry skid is empty; a stalled
// result drops into the skid so in_ready falls only while the skid holds a beat.
`timescale 1ns / 1ps
`default_nettype none
module disc_pair_collision (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dpc_pkg::CDW-1:0]        cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [dpc_pkg::VW-1:0]  pos_ax,
	input  logic signed [dpc_pkg::VW-1:0]  pos_ay,
	input  logic signed [dpc_pkg::VW-1:0]  vel_ax,
	input  logic signed [dpc_pkg::VW-1:0]  vel_ay,
	input  logic signed [dpc_pkg::VW-1:0]  pos_bx,
	input  logic signed [dpc_pkg::VW-1:0]  pos_by,
	input  logic signed [dpc_pkg::VW-1:0]  vel_bx,
	input  logic signed [dpc_pkg::VW-1:0]  vel_by,
	input  logic [dpc_pkg::MW-1:0]         mass_a,
	input  logic [dpc_pkg::MW-1:0]         mass_b,
	input  logic                           pocketed_a,
	input  logic                           pocketed_b,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic signed [dpc_pkg::VW-1:0]  new_vel_ax,
	output logic signed [dpc_pkg::VW-1:0]  new_vel_ay,
	output logic signed [dpc_pkg::VW-1:0]  new_vel_bx,
	output logic signed [dpc_pkg::VW-1:0]  new_vel_by
);
	import dpc_pkg::*;

	logic [CDW-1:0] cd_q;
	logic [NSTG:1]  vld_q;
	logic           en;
	result_t        skid_q;
	logic           skid_vld_q;

	// contact distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q <= CD_RESET;
		end else if (cfg_wr_en) begin
			cd_q <= cfg_wr_data;
		end
	end

	// whole pipeline moves while the skid is free
	assign en       = !skid_vld_q;
	assign in_ready = en;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-1:1], in_valid};
		end
	end

	// stage 1: differences, mass fix-up
	logic signed [VW:0] dx_c, dy_c, dvx_c, dvy_c;
	logic               mz_c;
	logic signed [VW:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [MW-1:0]      ma_s1, mb_s1;
	logic               live_s1;
	vel_t               vel_s1;

	assign dx_c  = {pos_ax[VW-1], pos_ax} - {pos_bx[VW-1], pos_bx};
	assign dy_c  = {pos_ay[VW-1], pos_ay} - {pos_by[VW-1], pos_by};
	assign dvx_c = {vel_ax[VW-1], vel_ax} - {vel_bx[VW-1], vel_bx};
	assign dvy_c = {vel_ay[VW-1], vel_ay} - {vel_by[VW-1], vel_by};
	assign mz_c  = (mass_a == '0) && (mass_b == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			dvx_s1  <= dvx_c;
			dvy_s1  <= dvy_c;
			ma_s1   <= mz_c ? MW'(1) : mass_a;
			mb_s1   <= mz_c ? MW'(1) : mass_b;
			live_s1 <= !pocketed_a && !pocketed_b;
			vel_s1  <= '{vax: vel_ax, vay: vel_ay, vbx: vel_bx, vby: vel_by};
		end
	end

	// stage 2: squares, closing products, |d| * 2m, contact distance squared
	logic signed [2*VW+1:0] dx2_c, dy2_c, cx_c, cy_c;
	logic [VW:0]            mx_c, my_c;
	logic [2*VW:0]          dx2_s2, dy2_s2;
	logic signed [2*VW+1:0] cx_s2, cy_s2;
	logic [2*CDW-1:0]       cd2_s2;
	logic [AMW-1:0]         am_s2 [4];
	logic [MW:0]            msum_s2;
	logic                   sgx_s2, sgy_s2, live_s2;
	vel_t                   vel_s2;

	assign dx2_c = dx_s1 * dx_s1;
	assign dy2_c = dy_s1 * dy_s1;
	assign cx_c  = dvx_s1 * dx_s1;
	assign cy_c  = dvy_s1 * dy_s1;
	assign mx_c  = dx_s1[VW] ? (VW+1)'(-dx_s1) : dx_s1;
	assign my_c  = dy_s1[VW] ? (VW+1)'(-dy_s1) : dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2   <= dx2_c[2*VW:0];
			dy2_s2   <= dy2_c[2*VW:0];
			cx_s2    <= cx_c;
			cy_s2    <= cy_c;
			cd2_s2   <= cd_q * cd_q;
			am_s2[0] <= mx_c * {mb_s1, 1'b0};
			am_s2[1] <= my_c * {mb_s1, 1'b0};
			am_s2[2] <= mx_c * {ma_s1, 1'b0};
			am_s2[3] <= my_c * {ma_s1, 1'b0};
			msum_s2  <= {1'b0, ma_s1} + {1'b0, mb_s1};
			sgx_s2   <= dx_s1[VW];
			sgy_s2   <= dy_s1[VW];
			live_s2  <= live_s1;
			vel_s2   <= vel_s1;
		end
	end

	// stage 3: distance squared, closing speed, hit decision
	logic [2*VW+1:0]        dist2_c;
	logic signed [2*VW+2:0] closing_c;
	logic                   hit_c;
	logic [2*CDW-1:0]       dist2_s3;
	logic signed [2*VW+2:0] closing_s3;
	logic [AMW-1:0]         am_s3 [4];
	logic [MW:0]            msum_s3;
	logic                   sgx_s3, sgy_s3, hit_s3;
	vel_t                   vel_s3;

	assign dist2_c   = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign closing_c = {cx_s2[2*VW+1], cx_s2} + {cy_s2[2*VW+1], cy_s2};
	assign hit_c     = live_s2 && (dist2_c != '0) && (dist2_c <= (2*VW+2)'(cd2_s2))
		&& closing_c[2*VW+2];

	always_ff @(posedge clk) begin
		if (en) begin
			dist2_s3   <= dist2_c[2*CDW-1:0];
			closing_s3 <= closing_c;
			am_s3      <= am_s2;
			msum_s3    <= msum_s2;
			sgx_s3     <= sgx_s2;
			sgy_s3     <= sgy_s2;
			hit_s3     <= hit_c;
			vel_s3     <= vel_s2;
		end
	end

	// stage 4: closing magnitude, denominator partial products
	logic [PW-1:0]      p_s4;
	logic [MW+CDW:0]    den_lo_s4, den_hi_s4;
	logic [AMW-1:0]     am_s4 [4];
	logic               sgx_s4, sgy_s4, hit_s4;
	vel_t               vel_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4      <= PW'(-closing_s3);
			den_lo_s4 <= msum_s3 * dist2_s3[CDW-1:0];
			den_hi_s4 <= msum_s3 * dist2_s3[2*CDW-1:CDW];
			am_s4     <= am_s3;
			sgx_s4    <= sgx_s3;
			sgy_s4    <= sgy_s3;
			hit_s4    <= hit_s3;
			vel_s4    <= vel_s3;
		end
	end

	// stage 5: numerator partial products, denominator sum
	logic [AMW+PH-1:0]  nlo_s5 [4];
	logic [AMW+PH-1:0]  nhi_s5 [4];
	logic [DENW-1:0]    den_s5;
	logic               sgx_s5, sgy_s5, hit_s5;
	vel_t               vel_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				nlo_s5[l] <= am_s4[l] * p_s4[PH-1:0];
				nhi_s5[l] <= am_s4[l] * p_s4[PW-1:PH];
			end
			den_s5 <= {den_hi_s4, CDW'(0)} + DENW'(den_lo_s4);
			sgx_s5 <= sgx_s4;
			sgy_s5 <= sgy_s4;
			hit_s5 <= hit_s4;
			vel_s5 <= vel_s4;
		end
	end

	// stage 6: full numerators
	logic [NUMW-1:0]    num_s6 [4];
	logic [DENW-1:0]    den_s6;
	logic               sgx_s6, sgy_s6, hit_s6;
	vel_t               vel_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				num_s6[l] <= {nhi_s5[l], PH'(0)} + NUMW'(nlo_s5[l]);
			end
			den_s6 <= den_s5;
			sgx_s6 <= sgx_s5;
			sgy_s6 <= sgy_s5;
			hit_s6 <= hit_s5;
			vel_s6 <= vel_s5;
		end
	end

	// stage 7 and divide steps: index 0 holds the overflow check and seeded remainder
	div_lane_t lane_sk [QBITS+1][4];
	div_side_t side_sk [QBITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				lane_sk[0][l].ovf   <= num_s6[l][NUMW-1:QBITS] >= (NUMW-QBITS)'(den_s6);
				lane_sk[0][l].rem   <= num_s6[l][QBITS+DENW-1:QBITS];
				lane_sk[0][l].nbits <= num_s6[l][QBITS-1:0];
				lane_sk[0][l].q     <= '0;
			end
			side_sk[0] <= '{hit: hit_s6, sgn_x: sgx_s6, sgn_y: sgy_s6, vel: vel_s6,
				den: den_s6};
			for (int k = 1; k <= QBITS; k++) begin
				for (int l = 0; l < 4; l++) begin
					lane_sk[k][l] <= div_step(lane_sk[k-1][l], side_sk[k-1].den);
				end
				side_sk[k] <= side_sk[k-1];
			end
		end
	end

	// output stage: clamp quotients, apply signs, saturate
	logic [QBITS:0] qf_c [4];
	div_side_t      sd_c;
	result_t        res_c;
	result_t        res_s32;

	always_comb begin
		sd_c = side_sk[QBITS];
		for (int l = 0; l < 4; l++) begin
			qf_c[l] = lane_sk[QBITS][l].ovf ? {1'b1, QBITS'(0)} : {1'b0, lane_sk[QBITS][l].q};
		end
		res_c.hit = sd_c.hit;
		if (sd_c.hit) begin
			res_c.nax = sat_add(sd_c.vel.vax, qf_c[0], sd_c.sgn_x);
			res_c.nay = sat_add(sd_c.vel.vay, qf_c[1], sd_c.sgn_y);
			res_c.nbx = sat_add(sd_c.vel.vbx, qf_c[2], !sd_c.sgn_x);
			res_c.nby = sat_add(sd_c.vel.vby, qf_c[3], !sd_c.sgn_y);
		end else begin
			res_c.nax = sd_c.vel.vax;
			res_c.nay = sd_c.vel.vay;
			res_c.nbx = sd_c.vel.vbx;
			res_c.nby = sd_c.vel.vby;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s32 <= res_c;
		end
	end

	// skid entry catches the output beat when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_q[NSTG] && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= res_s32;
		end
	end

	// output beat: skid first, it is the older one
	assign out_valid  = skid_vld_q || vld_q[NSTG];
	assign hit        = skid_vld_q ? skid_q.hit : res_s32.hit;
	assign new_vel_ax = skid_vld_q ? skid_q.nax : res_s32.nax;
	assign new_vel_ay = skid_vld_q ? skid_q.nay : res_s32.nay;
	assign new_vel_bx = skid_vld_q ? skid_q.nbx : res_s32.nbx;
	assign new_vel_by = skid_vld_q ? skid_q.nby : res_s32.nby;

endmodule
`default_nettype wire

### rtl/dpc_checker.sv
// port-level checks on the disc pair collision block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic signed [dpc_pkg::VW-1:0] new_vel_ax
);

	// an empty output side never backs up the input
	`DPC_ASSERT_IMP(a_idle_ready, clk, arst_n, !out_valid, in_ready)

	// input stalls only while a beat waits at the output
	`DPC_ASSERT_IMP(a_stall_has_out, clk, arst_n, !in_ready, out_valid)

	// draining the waiting beat frees the input on the next cycle
	`DPC_ASSERT_NXT(a_drain_frees, clk, arst_n, !in_ready && out_ready, in_ready)

	// a stalled output beat holds
	`DPC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(hit) && $stable(new_vel_ax))

endmodule

bind disc_pair_collision dpc_checker u_dpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hit        (hit),
	.new_vel_ax (new_vel_ax)
);
`default_nettype wire

### verif/disc_pair_collision_check.sv
// checker for disc_pair_collision: predicts each beat's result and compares it
`timescale 1ns / 1ps
`default_nettype none
module disc_pair_collision_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [dpc_pkg::CDW-1:0]       cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [dpc_pkg::VW-1:0] pos_ax,
	input  logic signed [dpc_pkg::VW-1:0] pos_ay,
	input  logic signed [dpc_pkg::VW-1:0] vel_ax,
	input  logic signed [dpc_pkg::VW-1:0] vel_ay,
	input  logic signed [dpc_pkg::VW-1:0] pos_bx,
	input  logic signed [dpc_pkg::VW-1:0] pos_by,
	input  logic signed [dpc_pkg::VW-1:0] vel_bx,
	input  logic signed [dpc_pkg::VW-1:0] vel_by,
	input  logic [dpc_pkg::MW-1:0]        mass_a,
	input  logic [dpc_pkg::MW-1:0]        mass_b,
	input  logic                          pocketed_a,
	input  logic                          pocketed_b,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          hit,
	input  logic signed [dpc_pkg::VW-1:0] new_vel_ax,
	input  logic signed [dpc_pkg::VW-1:0] new_vel_ay,
	input  logic signed [dpc_pkg::VW-1:0] new_vel_bx,
	input  logic signed [dpc_pkg::VW-1:0] new_vel_by,
	output int                            errors,
	output int                            pending
);
	import dpc_pkg::*;

	localparam logic [127:0] EXCHANGE_CAP = 128'h100_0000_0000;

	logic [CDW-1:0] contact_dist;
	result_t        expected_results[$];

	// clamp a velocity sum to the signed 24-bit range
	function automatic logic [VW-1:0] clamp_vel(input longint v);
		if (v > 64'sd8388607) begin
			return 24'h7FFFFF;
		end else if (v < -64'sd8388608) begin
			return 24'h800000;
		end
		return v[VW-1:0];
	endfunction

	// truncated magnitude of one velocity change, sign taken from the offset
	function automatic longint exchange_delta(input longint offs, input longint unsigned two_m,
		input longint unsigned closing, input longint unsigned denom);
		longint unsigned mag;
		logic [127:0]    num;
		logic [127:0]    quo;
		mag = (offs < 0) ? longint'(-offs) : longint'(offs);
		num = 128'(mag * two_m) * 128'(closing);
		quo = num / 128'(denom);
		if (quo > EXCHANGE_CAP) begin
			quo = EXCHANGE_CAP;
		end
		return (offs < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
	endfunction

	// collision test and elastic exchange for one disc pair
	function automatic result_t predict_collision(input longint pax, pay, vax, vay,
		pbx, pby, vbx, vby, input longint unsigned ma, mb, input logic pk_a, pk_b,
		input longint cd);
		result_t       r;
		longint        dx, dy, dist2, approach;
		longint        nax, nay, nbx, nby;
		longint unsigned closing, denom;
		dx    = pax - pbx;
		dy    = pay - pby;
		dist2 = dx * dx + dy * dy;
		nax   = vax;
		nay   = vay;
		nbx   = vbx;
		nby   = vby;
		r.hit = 1'b0;
		if (!pk_a && !pk_b && dist2 != 0 && dist2 <= cd * cd) begin
			approach = (vax - vbx) * dx + (vay - vby) * dy;
			if (approach < 0) begin
				r.hit   = 1'b1;
				closing = -approach;
				if (ma == 0 && mb == 0) begin
					ma = 1;
					mb = 1;
				end
				denom = (ma + mb) * longint'(dist2);
				nax = vax + exchange_delta(dx, 2 * mb, closing, denom);
				nay = vay + exchange_delta(dy, 2 * mb, closing, denom);
				nbx = vbx - exchange_delta(dx, 2 * ma, closing, denom);
				nby = vby - exchange_delta(dy, 2 * ma, closing, denom);
			end
		end
		r.nax = clamp_vel(nax);
		r.nay = clamp_vel(nay);
		r.nbx = clamp_vel(nbx);
		r.nby = clamp_vel(nby);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	assign pending = expected_results.size();

	// register copy, input beats and output beats
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			contact_dist = CD_RESET;
			expected_results.delete();
			errors = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_collision(pos_ax, pos_ay, vel_ax, vel_ay,
					pos_bx, pos_by, vel_bx, vel_by, mass_a, mass_b, pocketed_a, pocketed_b,
					longint'(contact_dist)));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat", hit, 0);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", hit, want.hit);
					if (new_vel_ax !== want.nax)
						report_mismatch("new_vel_ax", new_vel_ax, $signed(want.nax));
					if (new_vel_ay !== want.nay)
						report_mismatch("new_vel_ay", new_vel_ay, $signed(want.nay));
					if (new_vel_bx !== want.nbx)
						report_mismatch("new_vel_bx", new_vel_bx, $signed(want.nbx));
					if (new_vel_by !== want.nby)
						report_mismatch("new_vel_by", new_vel_by, $signed(want.nby));
				end
			end
			if (cfg_wr_en) begin
				contact_dist = cfg_wr_data;
			end
		end
	end

endmodule
`default_nettype wire

### verif/disc_pair_collision_test.sv
// stimulus, handshake pacing and verdict for disc_pair_collision
`timescale 1ns / 1ps
`default_nettype none
module disc_pair_collision_test;
	import dpc_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CDW-1:0]       cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [VW-1:0] pos_ax = '0, pos_ay = '0, vel_ax = '0, vel_ay = '0;
	logic signed [VW-1:0] pos_bx = '0, pos_by = '0, vel_bx = '0, vel_by = '0;
	logic [MW-1:0]        mass_a = 16'd1, mass_b = 16'd1;
	logic                 pocketed_a = 1'b0, pocketed_b = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 hit;
	logic signed [VW-1:0] new_vel_ax, new_vel_ay, new_vel_bx, new_vel_by;
	int                   errors, pending;
	int                   idle_cycles = 0;
	bit                   hold_request = 0;
	bit                   no_idle = 0;
	logic [CDW-1:0]       cur_dist = CD_RESET;

	disc_pair_collision uut (.*);

	disc_pair_collision_check checker_i (.*);

	always #6 clk = ~clk;

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver pacing, with one long hold-off on request
	always begin
		@(posedge clk);
		if (hold_request) begin
			hold_request = 0;
			out_ready <= 1'b0;
			repeat (LONG_HOLD) @(posedge clk);
		end else if (no_idle || $urandom_range(0, 9) < 7) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(10, 40)) @(posedge clk);
			else
				repeat ($urandom_range(0, 2)) @(posedge clk);
		end
	end

	// offer one pair and hold it until accepted
	task automatic send_pair(input logic signed [VW-1:0] pax, pay, vax, vay, pbx, pby, vbx, vby,
		input logic [MW-1:0] ma, mb, input logic pka, pkb);
		pos_ax <= pax; pos_ay <= pay; vel_ax <= vax; vel_ay <= vay;
		pos_bx <= pbx; pos_by <= pby; vel_bx <= vbx; vel_by <= vby;
		mass_a <= ma; mass_b <= mb; pocketed_a <= pka; pocketed_b <= pkb;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// sender gap after a beat, mostly none
	task automatic sender_gap();
		int g;
		g = 0;
		if (!no_idle) begin
			case ($urandom_range(0, 19))
				0: g = $urandom_range(10, 40);
				1, 2, 3, 4, 5: g = $urandom_range(1, 3);
				default: g = 0;
			endcase
		end
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_distance(input logic [CDW-1:0] d);
		wait_drained();
		repeat (40) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= d;
		cur_dist = d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [MW-1:0] rand_mass();
		case ($urandom_range(0, 7))
			0: return 16'd1;
			1: return 16'hFFFF;
			default: return MW'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic signed [VW-1:0] rand_vel();
		if ($urandom_range(0, 2) == 0)
			return VW'($urandom);
		return VW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
	endfunction

	// one random pair: mostly discs within reach, the rest raw noise
	task automatic random_pair();
		int reach, pax, pay, dx, dy;
		reach = (cur_dist > 4194303) ? 4194303 : int'(cur_dist);
		if ($urandom_range(0, 4) == 0) begin
			send_pair(VW'($urandom), VW'($urandom), VW'($urandom), VW'($urandom),
				VW'($urandom), VW'($urandom), VW'($urandom), VW'($urandom),
				MW'($urandom_range(1, 65535)), MW'($urandom_range(1, 65535)),
				1'($urandom), 1'($urandom));
		end else begin
			pax = int'($urandom_range(0, 8388606)) - 4194303;
			pay = int'($urandom_range(0, 8388606)) - 4194303;
			dx  = int'($urandom_range(0, 2 * reach)) - reach;
			dy  = int'($urandom_range(0, 2 * reach)) - reach;
			send_pair(VW'(pax), VW'(pay), rand_vel(), rand_vel(), VW'(pax - dx), VW'(pay - dy),
				rand_vel(), rand_vel(), rand_mass(), rand_mass(),
				$urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
		end
		sender_gap();
	endtask

	localparam logic signed [VW-1:0] VMAX = 24'sh7FFFFF;
	localparam logic signed [VW-1:0] VMIN = -24'sh800000;
	localparam logic signed [VW-1:0] ONE  = 24'sh010000;

	initial begin
		logic [CDW-1:0] phase_dist[6];
		phase_dist = '{23'd0, 23'h7FFFFF, 23'd131072, 23'd3000, 23'd1048576, 23'd0};
		phase_dist[5] = CDW'($urandom_range(1, 8388607));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at reset contact distance of 1.0
		send_pair(0, 0, ONE, 0, 0, 0, -ONE, 0, 16'h100, 16'h100, 0, 0);      // coincident
		send_pair(ONE, 0, -ONE, 0, 0, 0, ONE, 0, 16'h100, 16'h100, 0, 0);    // touching head-on
		send_pair(ONE + 1, 0, -ONE, 0, 0, 0, ONE, 0, 16'h100, 16'h100, 0, 0); // just apart
		send_pair(ONE / 2, 0, ONE, 0, 0, 0, -ONE, 0, 16'h100, 16'h100, 0, 0); // separating
		send_pair(0, ONE / 2, ONE, 0, 0, 0, -ONE, 0, 16'h100, 16'h100, 0, 0); // sliding
		send_pair(ONE / 2, 0, -ONE, 0, 0, 0, 0, 0, 16'h100, 16'h100, 1, 0);   // a pocketed
		send_pair(ONE / 2, 0, -ONE, 0, 0, 0, 0, 0, 16'h100, 16'h100, 0, 1);   // b pocketed
		send_pair(ONE / 2, 0, -ONE, 0, 0, 0, 0, 0, 16'h100, 16'h100, 1, 1);   // both pocketed
		send_pair(ONE / 2, ONE / 3, VMIN, VMIN, 0, 0, VMAX, VMAX, 16'd1, 16'hFFFF, 0, 0);
		send_pair(ONE / 2, -ONE / 3, VMIN, VMAX, 0, 0, VMAX, VMIN, 16'hFFFF, 16'd1, 0, 0);
		send_pair(1, 0, VMIN, 0, 0, 0, VMAX, 0, 16'hFFFF, 16'hFFFF, 0, 0);   // tiny gap
		send_pair(-1, -1, VMAX, VMAX, 0, 0, VMIN, VMIN, 16'd1, 16'd1, 0, 0);
		send_pair(VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, VMIN, VMAX, 16'd1, 16'hFFFF, 0, 0);
		send_pair(VMIN, VMIN, 0, 0, VMAX, VMAX, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0);
		send_pair(-ONE / 2, ONE / 2, ONE, -ONE, 0, 0, 0, 0, 16'h0180, 16'h0040, 0, 0);

		// random phases over several contact distances
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0)
				write_distance(phase_dist[ph - 1]);
			no_idle = (ph == 3);
			for (int k = 0; k < 200; k++) begin
				if (ph == 2 && k == 20)
					hold_request = 1;
				if (ph == 4 && k == 100)
					wait_drained();
				random_pair();
			end
		end

		// touching exactly at the largest contact distance
		write_distance(23'h7FFFFF);
		send_pair(24'sh3FFFFF, 0, -ONE, 0, -24'sh400000, 0, ONE, 0, 16'h100, 16'h200, 0, 0);
		send_pair(24'sh3FFFFF, 0, -ONE, 0, -24'sh400001, 0, ONE, 0, 16'h100, 16'h200, 0, 0);
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
